// File: hdl/ttce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and constants of the text terminal cursor engine: request and
// command codes, configuration record, drawing command record and port widths.
// ----------------------------------------------------------------------------
package ttce_pkg;

	// port widths
	localparam int IN_DATA_W  = 40;  // char_code, new_col, new_row
	localparam int OUT_DATA_W = 40;  // glyph_index, pixel_x, pixel_y, pen, pad
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 10;

	// behaviour constants
	localparam logic [2:0]  BLINK_TICKS    = 3'd6;
	localparam logic [15:0] TOP_MARGIN     = 16'd10;
	localparam logic [7:0]  CURSOR_CODE    = 8'd127;
	localparam logic [7:0]  MISSING_CODE   = 8'd63;
	localparam logic [7:0]  SPACE_CODE     = 8'd32;
	localparam logic [7:0]  NEWLINE_CODE   = 8'd10;
	localparam logic [7:0]  BACKSPACE_CODE = 8'd8;
	localparam logic [9:0]  COL_LIMIT      = 10'd639;
	localparam logic [8:0]  ROW_LIMIT      = 9'd479;
	localparam logic [15:0] PIX_MAX        = 16'd16383;

	// request kinds on the input tuser
	typedef enum logic [1:0] {
		REQ_CHAR = 2'd0,
		REQ_TICK = 2'd1,
		REQ_MOVE = 2'd2
	} req_t;

	// command kinds on the output tuser
	typedef enum logic [1:0] {
		CMD_GLYPH  = 2'd0,
		CMD_SCROLL = 2'd1,
		CMD_CURSOR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PEN_FG     = 2'd0,
		PEN_SHOWN  = 2'd1,
		PEN_HIDDEN = 2'd2
	} pen_t;

	// configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_GLYPH_W  = 3'd0,
		CFG_GLYPH_H  = 3'd1,
		CFG_LOW_CODE = 3'd2,
		CFG_HIGH_CODE = 3'd3,
		CFG_COLUMNS  = 3'd4,
		CFG_ROWS     = 3'd5,
		CFG_LEFT_MAR = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0] glyph_width;
		logic [5:0] glyph_height;
		logic [7:0] lowest_code;
		logic [7:0] highest_code;
		logic [6:0] text_columns;
		logic [6:0] text_rows;
		logic [9:0] left_margin;
	} cfg_t;

	// one drawing command before pixel placement
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] glyph;
		logic [9:0] col;
		logic [8:0] row;
		pen_t       pen;
		logic       at_cell;
	} ent_t;

	// up to three commands caused by one item
	typedef struct packed {
		logic       load;
		logic [1:0] count;
		ent_t [2:0] ent;
	} burst_t;

endpackage

// File: hdl/text_terminal_cursor_engine.sv
`timescale 1ns / 1ps
// Path: an item passes through the input register, the command queue and the output register.
// Throughput: one command per cycle through the single output register while m_tready is high; an item's
// commands, one to three, are sent in order, and items without commands leave from the input stage.
// Reset (arst_n low): cursor at column 0 row 0, shown, blink countdown six, registers to defaults,
// input stage, command queue and output register empty.
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine
// Text mode cursor engine: characters, blink ticks and cursor moves in,
// glyph, scroll and cursor drawing commands out.
// ----------------------------------------------------------------------------
module text_terminal_cursor_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ttce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ttce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// char_code [7:0], new_col [23:8], new_row [39:24]
	input  logic [ttce_pkg::IN_DATA_W-1:0]   s_tdata,
	// req_type [1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// glyph_index [7:0], pixel_x [21:8], pixel_y [35:22], pen [37:36], zero [39:38]
	output logic [ttce_pkg::OUT_DATA_W-1:0]  m_tdata,
	// command [1:0]
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);
	import ttce_pkg::*;

	cfg_t   cfg;
	burst_t burst;
	logic   burst_ready;

	// configuration registers
	ttce_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input stage and cursor decode
	ttce_cursor_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.burst_ready (burst_ready),
		.burst       (burst)
	);

	// command queue and output register
	ttce_cmd_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.burst       (burst),
		.burst_ready (burst_ready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast)
	);

	// the cursor command always closes an item
	a_last_is_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != CMD_CURSOR |-> !m_tlast)
		else $error("non-cursor command marked last");

	// a scroll carries no glyph, position or pen
	a_scroll_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == CMD_SCROLL |-> m_tdata[37:0] == 38'd0)
		else $error("scroll command with non-zero fields");

	// a cursor command is drawn shown or hidden, never with the text pen
	a_cursor_pen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == CMD_CURSOR |-> m_tdata[37:36] != PEN_FG)
		else $error("cursor command with text pen");

	// a new command set is only loaded when the queue can take it
	a_queue_load: assert property (@(posedge clk) disable iff (!arst_n)
		burst.load |-> burst_ready)
		else $error("command set loaded over pending commands");

endmodule

// File: hdl/ttce_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_cfg_regs
// Configuration register file, write only, with the font and screen geometry.
// ----------------------------------------------------------------------------
module ttce_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ttce_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [ttce_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output ttce_pkg::cfg_t                   cfg
);
	import ttce_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width  <= 5'd8;
			cfg_q.glyph_height <= 6'd16;
			cfg_q.lowest_code  <= 8'd32;
			cfg_q.highest_code <= 8'd127;
			cfg_q.text_columns <= 7'd80;
			cfg_q.text_rows    <= 7'd25;
			cfg_q.left_margin  <= 10'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_GLYPH_W:   cfg_q.glyph_width  <= cfg_wdata[4:0];
				CFG_GLYPH_H:   cfg_q.glyph_height <= cfg_wdata[5:0];
				CFG_LOW_CODE:  cfg_q.lowest_code  <= cfg_wdata[7:0];
				CFG_HIGH_CODE: cfg_q.highest_code <= cfg_wdata[7:0];
				CFG_COLUMNS:   cfg_q.text_columns <= cfg_wdata[6:0];
				CFG_ROWS:      cfg_q.text_rows    <= cfg_wdata[6:0];
				CFG_LEFT_MAR:  cfg_q.left_margin  <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/ttce_cursor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_cursor_core
// Input register, cursor and blink state, and the single-pass decode that
// turns one item into its list of drawing commands.
// ----------------------------------------------------------------------------
module ttce_cursor_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ttce_pkg::cfg_t                   cfg,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ttce_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             burst_ready,
	output ttce_pkg::burst_t                 burst
);
	import ttce_pkg::*;

	// input stage
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [7:0]  code_s1;
	logic [15:0] ncol_s1;
	logic [15:0] nrow_s1;

	// cursor state
	logic [9:0] col_q;
	logic [8:0] row_q;
	logic       vis_q;
	logic [2:0] blink_q;

	// decode results
	logic [9:0] col_d;
	logic [8:0] row_d;
	logic       vis_d;
	logic [2:0] blink_d;
	logic [1:0] count_d;
	ent_t [2:0] ent_d;
	logic       s1_fire;

	// item decode
	always_comb begin
		logic [9:0] col1;
		logic [8:0] row1;
		logic [9:0] col2;
		logic [8:0] row2;
		logic [8:0] row3;
		logic       has_first;
		logic       has_scroll;
		logic       has_cursor;
		logic [2:0] bc1;
		ent_t       first;
		ent_t       scroll;
		ent_t       cur;

		col1 = col_q;
		row1 = row_q;
		col2 = col_q;
		row2 = row_q;
		row3 = row_q;
		has_first  = 1'b0;
		has_scroll = 1'b0;
		has_cursor = 1'b0;
		bc1 = blink_q - 3'd1;
		first  = '{cmd: CMD_GLYPH, glyph: 8'd0, col: col_q, row: row_q,
			pen: PEN_FG, at_cell: 1'b1};
		scroll = '{cmd: CMD_SCROLL, glyph: 8'd0, col: 10'd0, row: 9'd0,
			pen: PEN_FG, at_cell: 1'b0};
		cur    = '{cmd: CMD_CURSOR, glyph: CURSOR_CODE - cfg.lowest_code, col: col_q,
			row: row_q, pen: PEN_SHOWN, at_cell: 1'b1};
		col_d   = col_q;
		row_d   = row_q;
		vis_d   = vis_q;
		blink_d = blink_q;

		unique case (req_t'(req_s1))
			REQ_CHAR: begin
				// first command and cursor step
				if (code_s1 == NEWLINE_CODE) begin
					has_first   = 1'b1;
					first.cmd   = CMD_CURSOR;
					first.glyph = CURSOR_CODE - cfg.lowest_code;
					first.pen   = PEN_HIDDEN;
					col1 = 10'd0;
					row1 = row_q + 9'd1;
				end else if (code_s1 == BACKSPACE_CODE) begin
					if (col_q != 10'd0) begin
						has_first   = 1'b1;
						first.glyph = SPACE_CODE - cfg.lowest_code;
						col1 = col_q - 10'd1;
					end
				end else begin
					has_first = 1'b1;
					if (code_s1 < cfg.lowest_code || code_s1 > cfg.highest_code)
						first.glyph = MISSING_CODE - cfg.lowest_code;
					else
						first.glyph = code_s1 - cfg.lowest_code;
					col1 = col_q + 10'd1;
				end
				// column wrap
				if (col1 >= {3'd0, cfg.text_columns}) begin
					col2 = 10'd0;
					row2 = row1 + 9'd1;
				end else begin
					col2 = col1;
					row2 = row1;
				end
				// scroll at the bottom
				if (row2 >= {2'd0, cfg.text_rows}) begin
					has_scroll = 1'b1;
					row3 = (cfg.text_rows == 7'd0) ? 9'd0
						: {2'd0, cfg.text_rows - 7'd1};
				end else begin
					row3 = row2;
				end
				has_cursor = 1'b1;
				cur.col = col2;
				cur.row = row3;
				col_d   = col2;
				row_d   = row3;
				vis_d   = 1'b1;
				blink_d = BLINK_TICKS;
			end
			REQ_TICK: begin
				if (bc1 == 3'd0) begin
					has_cursor = 1'b1;
					vis_d   = !vis_q;
					blink_d = BLINK_TICKS;
					cur.pen = vis_q ? PEN_HIDDEN : PEN_SHOWN;
				end else begin
					blink_d = bc1;
				end
			end
			REQ_MOVE: begin
				col_d = (ncol_s1 > {6'd0, COL_LIMIT}) ? COL_LIMIT : ncol_s1[9:0];
				row_d = (nrow_s1 > {7'd0, ROW_LIMIT}) ? ROW_LIMIT : nrow_s1[8:0];
			end
			default: ;
		endcase

		// pack the commands in order, cursor always last
		ent_d[0] = has_first ? first : (has_scroll ? scroll : cur);
		ent_d[1] = (has_first && has_scroll) ? scroll : cur;
		ent_d[2] = cur;
		if (has_cursor)
			count_d = 2'd1 + {1'b0, has_first} + {1'b0, has_scroll};
		else
			count_d = 2'd0;
	end

	// item leaves the input stage once its commands have a place to go
	assign s1_fire  = valid_s1 && (count_d == 2'd0 || burst_ready);
	assign s_tready = !valid_s1 || s1_fire;

	assign burst.load  = s1_fire && (count_d != 2'd0);
	assign burst.count = count_d;
	assign burst.ent   = ent_d;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= s_tuser;
			code_s1 <= s_tdata[7:0];
			ncol_s1 <= s_tdata[23:8];
			nrow_s1 <= s_tdata[39:24];
		end
	end

	// cursor and blink state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= 10'd0;
			row_q   <= 9'd0;
			vis_q   <= 1'b1;
			blink_q <= BLINK_TICKS;
		end else if (s1_fire) begin
			col_q   <= col_d;
			row_q   <= row_d;
			vis_q   <= vis_d;
			blink_q <= blink_d;
		end
	end

endmodule

// File: hdl/ttce_cmd_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_cmd_out
// Holds the commands of one item, sends them one per cycle while m_tready does not stall
// the output, places each one in pixels and drives the output register.
// ----------------------------------------------------------------------------
module ttce_cmd_out (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ttce_pkg::cfg_t                   cfg,
	input  ttce_pkg::burst_t                 burst,
	output logic                             burst_ready,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ttce_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [1:0]                       m_tuser,
	output logic                             m_tlast
);
	import ttce_pkg::*;

	ent_t [2:0] ent_q;
	logic [1:0] rem_q;

	logic        out_free;
	logic        pop;
	logic [14:0] prod_x;
	logic [14:0] prod_y;
	logic [15:0] sum_x;
	logic [15:0] sum_y;
	logic [13:0] px;
	logic [13:0] py;

	logic [7:0]  glyph_q;
	logic [13:0] px_q;
	logic [13:0] py_q;
	pen_t        pen_q;
	cmd_t        cmd_q;
	logic        last_q;

	assign out_free    = !m_tvalid || m_tready;
	assign pop         = (rem_q != 2'd0) && out_free;
	assign burst_ready = (rem_q == 2'd0) || (rem_q == 2'd1 && pop);

	// command queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rem_q <= 2'd0;
		else if (burst.load)
			rem_q <= burst.count;
		else if (pop)
			rem_q <= rem_q - 2'd1;
	end

	// command queue payload, head always in slot zero
	always_ff @(posedge clk) begin
		if (burst.load) begin
			ent_q <= burst.ent;
		end else if (pop) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
		end
	end

	// pixel placement of the head command, saturating
	assign prod_x = 15'(ent_q[0].col) * 15'(cfg.glyph_width);
	assign prod_y = 15'(ent_q[0].row) * 15'(cfg.glyph_height);
	assign sum_x  = {6'd0, cfg.left_margin} + {1'b0, prod_x};
	assign sum_y  = TOP_MARGIN + {1'b0, prod_y};

	always_comb begin
		if (!ent_q[0].at_cell) begin
			px = 14'd0;
			py = 14'd0;
		end else begin
			px = (sum_x > PIX_MAX) ? PIX_MAX[13:0] : sum_x[13:0];
			py = (sum_y > PIX_MAX) ? PIX_MAX[13:0] : sum_y[13:0];
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (out_free)
			m_tvalid <= (rem_q != 2'd0);
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q   <= ent_q[0].cmd;
			glyph_q <= ent_q[0].glyph;
			px_q    <= px;
			py_q    <= py;
			pen_q   <= ent_q[0].pen;
			last_q  <= (rem_q == 2'd1);
		end
	end

	assign m_tdata = {2'b00, pen_q, py_q, px_q, glyph_q};
	assign m_tuser = cmd_q;
	assign m_tlast = last_q;

endmodule
